[hw/rtl/bmhq_pkg.sv]
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and defaults for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int KEY_BITS_DEF    = 16;
    localparam int HANDLE_BITS_DEF = 16;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_RM_RD,
        S_RM_LOAD,
        S_DN_RD,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_OUT
    } t_state;

endpackage

[hw/rtl/binary_min_heap_queue_core.sv]
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core
// Array-based binary min-heap of (cost, handle) pairs with insert and
// remove-minimum, sifting through a single memory with one key comparator.
// ----------------------------------------------------------------------------
//  channel | handshake                    | payload
//  --------+------------------------------+------------------------------------
//  input   | i_in_valid / o_in_stall      | i_operation, i_cost_key,
//          |                              | i_item_handle
//  output  | o_out_valid / i_out_stall    | o_out_cost, o_out_handle,
//          |                              | o_status, o_entry_count
//
//  Each level the entry moves (at most log2(CAPACITY)) costs one memory read and
//  one comparator pass for an insert, two for a removal; a removal first reads
//  the root and the last slot and loads them. An error beat is offered in the
//  cycle after acceptance.
//  Reset empties the heap at once; slots are not cleared.
//  The result beat holds while i_out_stall is high; no new beat is taken then.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core
    import bmhq_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_operation,
    input  logic [KEY_BITS-1:0]             i_cost_key,
    input  logic [HANDLE_BITS-1:0]          i_item_handle,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [KEY_BITS-1:0]             o_out_cost,
    output logic [HANDLE_BITS-1:0]          o_out_handle,
    output logic [1:0]                      o_status,
    output logic [$clog2(CAPACITY+1)-1:0]   o_entry_count
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CIW = AW + 2;
    localparam int EW  = KEY_BITS + HANDLE_BITS;

    logic [EW-1:0] r_mem [CAPACITY];

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_pos, n_pos;
    logic [EW-1:0]      r_mv, n_mv;
    logic               r_pick_left, n_pick_left;
    logic [EW-1:0]      r_rd_a, r_rd_b;
    logic [KEY_BITS-1:0]    r_out_cost, n_out_cost;
    logic [HANDLE_BITS-1:0] r_out_handle, n_out_handle;
    t_status            r_status, n_status;

    logic               in_acc;
    logic               is_full, is_empty;
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr_a, rd_addr_b, wr_addr;
    logic [EW-1:0]      wr_data;
    logic [CW-1:0]      cnt_m1;
    logic [AW-1:0]      pos_m1, parent;
    logic [CIW-1:0]     left_idx, right_idx;
    logic               left_ok, right_ok;
    logic [KEY_BITS-1:0] mv_key, a_key, b_key;
    logic [KEY_BITS-1:0] cmp_a, cmp_b;
    logic               cmp_lt;

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign is_full   = (r_count == CW'(CAPACITY));
    assign is_empty  = (r_count == '0);
    assign cnt_m1    = r_count - 1'b1;
    assign pos_m1    = r_pos - 1'b1;
    assign parent    = pos_m1 >> 1;
    assign left_idx  = {1'b0, r_pos, 1'b1};
    assign right_idx = {1'b0, r_pos, 1'b0} + CIW'(2);
    assign left_ok   = left_idx < CIW'(r_count);
    assign right_ok  = right_idx < CIW'(r_count);

    assign mv_key = r_mv[EW-1 -: KEY_BITS];
    assign a_key  = r_rd_a[EW-1 -: KEY_BITS];
    assign b_key  = r_rd_b[EW-1 -: KEY_BITS];

    // Shared key comparator; its operands follow the sequencer state.
    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        case (r_state)
            S_UP_CMP: begin
                cmp_a = mv_key;
                cmp_b = a_key;
            end
            S_DN_LEFT: begin
                cmp_a = a_key;
                cmp_b = mv_key;
            end
            S_DN_RIGHT: begin
                cmp_a = b_key;
                cmp_b = r_pick_left ? a_key : mv_key;
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_lt = cmp_a < cmp_b;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_operation == OP_INSERT) begin
                        n_state = is_full ? S_OUT : S_UP_RD;
                    end else begin
                        n_state = is_empty ? S_OUT : S_RM_RD;
                    end
                end
            end
            S_UP_RD:    n_state = (r_pos == '0) ? S_OUT : S_UP_CMP;
            S_UP_CMP:   n_state = cmp_lt ? S_UP_RD : S_OUT;
            S_RM_RD:    n_state = S_RM_LOAD;
            S_RM_LOAD:  n_state = (cnt_m1 == '0) ? S_OUT : S_DN_RD;
            S_DN_RD:    n_state = S_DN_LEFT;
            S_DN_LEFT:  n_state = S_DN_RIGHT;
            S_DN_RIGHT: begin
                if ((right_ok && cmp_lt) || r_pick_left) begin
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath control. The entry being placed is kept in r_mv and the hole
    // at r_pos is filled by the parent or child that moves past it.
    always_comb begin
        rd_en        = 1'b0;
        rd_addr_a    = '0;
        rd_addr_b    = '0;
        wr_en        = 1'b0;
        wr_addr      = r_pos;
        wr_data      = r_mv;
        n_count      = r_count;
        n_pos        = r_pos;
        n_mv         = r_mv;
        n_pick_left  = r_pick_left;
        n_out_cost   = r_out_cost;
        n_out_handle = r_out_handle;
        n_status     = r_status;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out_cost   = '0;
                    n_out_handle = '0;
                    n_status     = ST_DONE;
                    if (i_operation == OP_INSERT) begin
                        if (is_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_mv    = {i_cost_key, i_item_handle};
                            n_pos   = r_count[AW-1:0];
                            n_count = r_count + 1'b1;
                        end
                    end else if (is_empty) begin
                        n_status = ST_EMPTY;
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    wr_en = 1'b1;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr_a = parent;
                end
            end
            S_UP_CMP: begin
                wr_en = 1'b1;
                if (cmp_lt) begin
                    wr_data = r_rd_a;
                    n_pos   = parent;
                end
            end
            S_RM_RD: begin
                rd_en     = 1'b1;
                rd_addr_a = '0;
                rd_addr_b = cnt_m1[AW-1:0];
            end
            S_RM_LOAD: begin
                n_out_cost   = a_key;
                n_out_handle = r_rd_a[HANDLE_BITS-1:0];
                n_mv         = r_rd_b;
                n_count      = cnt_m1;
                n_pos        = '0;
            end
            S_DN_RD: begin
                // A child index past the count reads a stale slot that is
                // then ignored.
                rd_en     = 1'b1;
                rd_addr_a = left_idx[AW-1:0];
                rd_addr_b = right_idx[AW-1:0];
            end
            S_DN_LEFT: begin
                n_pick_left = left_ok && cmp_lt;
            end
            S_DN_RIGHT: begin
                wr_en = 1'b1;
                if (right_ok && cmp_lt) begin
                    wr_data = r_rd_b;
                    n_pos   = right_idx[AW-1:0];
                end else if (r_pick_left) begin
                    wr_data = r_rd_a;
                    n_pos   = left_idx[AW-1:0];
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_out_cost    = r_out_cost;
    assign o_out_handle  = r_out_handle;
    assign o_status      = r_status;
    assign o_entry_count = r_count;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pick_left <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pick_left <= n_pick_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_mv         <= n_mv;
        r_out_cost   <= n_out_cost;
        r_out_handle <= n_out_handle;
        r_status     <= n_status;
    end

endmodule

[hw/rtl/bmhq_checker.sv]
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
module bmhq_checker
    import bmhq_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_stall,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic [KEY_BITS-1:0]             o_out_cost,
    input  logic [HANDLE_BITS-1:0]          o_out_handle,
    input  logic [1:0]                      o_status,
    input  logic [$clog2(CAPACITY+1)-1:0]   o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic out_beat;
    assign out_beat = o_out_valid && !i_out_stall;

    // The count never exceeds the heap size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // A removal from an empty heap reports an empty heap and no item.
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && (o_status == ST_EMPTY) |->
            (o_entry_count == '0) && (o_out_cost == '0) && (o_out_handle == '0))
        else $error("empty status with entries or data");

    // An insert rejected as full reports a full heap.
    a_full_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && (o_status == ST_FULL) |-> o_entry_count == CW'(CAPACITY))
        else $error("full status with free slots");

    // No new beat is taken while a result is waiting.
    a_busy_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

endmodule

bind binary_min_heap_queue_core bmhq_checker #(
    .CAPACITY    (CAPACITY),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
) u_bmhq_checker (.*);
